FILE: design/sfps_pkg.sv
// Shared types and constants of the starfield perspective step.
package sfps_pkg;

  // Field widths of the request and result items
  localparam int IdxW   = 9;
  localparam int CoordW = 6;
  localparam int DepthW = 14;
  localparam int StepW  = 8;
  localparam int PxW    = 7;
  localparam int PyW    = 6;
  localparam int DotW   = 2;

  // Stream word widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 16;

  // Screen and depth geometry
  localparam int SCREEN_W   = 128;
  localparam int SCREEN_H   = 64;
  localparam int MAX_DEPTH  = 32;
  localparam int FULL_DEPTH = MAX_DEPTH * 256;
  localparam int XScale     = SCREEN_W * 256;
  localparam int OriginX    = SCREEN_W / 2;
  localparam int OriginY    = SCREEN_H / 2;

  // Projection numerator: signed width and magnitude width
  localparam int NumSW = 22;
  localparam int NumW  = NumSW - 1;

  // Reset value of the depth step register
  localparam logic [StepW-1:0] STEP_RESET = StepW'(49);

  // Request kinds
  localparam logic REQ_PLACE   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // One stored star
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [DepthW-1:0]        z;
  } star_t;

  // One divider stage: partial remainders, numerator/quotient shift words
  typedef struct packed {
    logic              proj;
    logic              neg_x;
    logic              neg_y;
    logic [DepthW-1:0] rem_x;
    logic [DepthW-1:0] rem_y;
    logic [NumW-1:0]   nq_x;
    logic [NumW-1:0]   nq_y;
    logic [DepthW-1:0] z;
    logic [DotW-1:0]   dot;
  } div_t;

  // One result item
  typedef struct packed {
    logic [DotW-1:0] dot;
    logic [PyW-1:0]  py;
    logic [PxW-1:0]  px;
    logic            vis;
  } res_t;

endpackage

FILE: design/starfield_perspective_step.sv
// Top level of the starfield perspective step: star store and projection pipeline.
//
// Takes one request per cycle while s_axis_tready is high and returns exactly
// one result per request, in order. The projection divider resolves one quotient
// bit per stage over 21 stages for x and y side by side; the star store is a single
// memory read at acceptance and written back from stage 1, with a bypass for
// back-to-back requests to the same star. After reset the block zeroes all STARS
// entries (512 by default) of the store and holds s_axis_tready low until that
// pass ends; depth_step may be written meanwhile. An output register plus a skid
// register decouple m_axis_tready from s_axis_tready.
module starfield_perspective_step
  import sfps_pkg::*;
#(
  parameter int STARS = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: depth_step
  input  logic                cfg_we_i,
  input  logic [StepW-1:0]    cfg_wdata_i,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: star_index[8:0], given_x[14:9], given_y[20:15], given_depth[34:21], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: req_type
  input  logic                s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: pixel_x[6:0], pixel_y[12:7], dot_size[14:13], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: visible
  output logic                m_axis_tuser
);

  localparam int AW = (STARS > 1) ? $clog2(STARS) : 1;

  // Unpack request
  logic [IdxW-1:0]          in_idx;
  logic signed [CoordW-1:0] in_gx;
  logic signed [CoordW-1:0] in_gy;
  logic [DepthW-1:0]        in_gd;

  assign in_idx = s_axis_tdata[IdxW-1:0];
  assign in_gx  = s_axis_tdata[IdxW+CoordW-1:IdxW];
  assign in_gy  = s_axis_tdata[IdxW+2*CoordW-1:IdxW+CoordW];
  assign in_gd  = s_axis_tdata[IdxW+2*CoordW+DepthW-1:IdxW+2*CoordW];

  // Depth step register
  logic [StepW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Pipeline advance and request acceptance
  logic en;
  logic skid_vld_q;
  logic clr_busy_q;
  logic in_acc;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en && !clr_busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Clearing pass over the store after reset
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(STARS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Stage 1: request with the store read
  logic                     p1_vld_q;
  logic                     p1_req_q;
  logic                     p1_inr_q;
  logic [AW-1:0]            p1_idx_q;
  logic signed [CoordW-1:0] p1_gx_q;
  logic signed [CoordW-1:0] p1_gy_q;
  logic [DepthW-1:0]        p1_gd_q;
  star_t                    rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_req_q <= s_axis_tuser;
      p1_inr_q <= (32'(in_idx) < STARS);
      p1_idx_q <= AW'(in_idx);
      p1_gx_q  <= in_gx;
      p1_gy_q  <= in_gy;
      p1_gd_q  <= in_gd;
    end
  end

  // Star store
  star_t         mem [0:STARS-1];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  star_t         mem_wdata;
  logic          p1_wr;
  star_t         p1_new;

  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = p1_wr && en;
      mem_waddr = p1_idx_q;
      mem_wdata = p1_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (en) begin
      rd_q <= mem[AW'(in_idx)];
    end
  end

  // Bypass of the write made at the previous advance
  logic          byp_vld_q;
  logic [AW-1:0] byp_idx_q;
  star_t         byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else if (en) begin
      byp_vld_q <= p1_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      byp_idx_q <= p1_idx_q;
      byp_q     <= p1_new;
    end
  end

  // Stage 1 logic: advance depth, respawn, place
  star_t             p1_cur;
  logic              p1_respawn;
  logic [DepthW-1:0] p1_zsub;
  logic              p1_proj;

  always_comb begin
    p1_cur     = (byp_vld_q && (byp_idx_q == p1_idx_q)) ? byp_q : rd_q;
    p1_respawn = (p1_cur.z <= DepthW'(step_q));
    p1_zsub    = p1_cur.z - DepthW'(step_q);
    p1_wr      = p1_vld_q && p1_inr_q;
    p1_proj    = p1_inr_q && (p1_req_q == REQ_ADVANCE);
    if (p1_req_q == REQ_PLACE) begin
      p1_new = '{x: p1_gx_q, y: p1_gy_q, z: p1_gd_q};
    end else if (p1_respawn) begin
      p1_new = '{x: p1_gx_q, y: p1_gy_q, z: DepthW'(FULL_DEPTH)};
    end else begin
      p1_new = '{x: p1_cur.x, y: p1_cur.y, z: p1_zsub};
    end
  end

  // Stage 2: updated star
  logic  p2_vld_q;
  logic  p2_proj_q;
  star_t p2_star_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_proj_q <= p1_proj;
      p2_star_q <= p1_new;
    end
  end

  // Stage 2 logic: projection numerators, magnitudes and dot size
  logic signed [NumSW-1:0] p2_xs;
  logic signed [NumSW-1:0] p2_ys;
  logic signed [NumSW-1:0] p2_zs;
  logic signed [NumSW-1:0] p2_num_x;
  logic signed [NumSW-1:0] p2_num_y;
  logic signed [NumSW-1:0] p2_mag_x;
  logic signed [NumSW-1:0] p2_mag_y;
  logic [DepthW:0]         p2_dd;
  div_t                    p2_div;

  always_comb begin
    p2_xs    = NumSW'(p2_star_q.x);
    p2_ys    = NumSW'(p2_star_q.y);
    p2_zs    = NumSW'({1'b0, p2_star_q.z});
    p2_num_x = p2_xs * NumSW'(XScale) + p2_zs * NumSW'(OriginX);
    p2_num_y = p2_ys * NumSW'(XScale) + p2_zs * NumSW'(OriginY);
    p2_mag_x = p2_num_x[NumSW-1] ? -p2_num_x : p2_num_x;
    p2_mag_y = p2_num_y[NumSW-1] ? -p2_num_y : p2_num_y;
    p2_dd    = (DepthW+1)'(FULL_DEPTH) - (DepthW+1)'(p2_star_q.z);
    p2_div.proj  = p2_proj_q;
    p2_div.neg_x = p2_num_x[NumSW-1];
    p2_div.neg_y = p2_num_y[NumSW-1];
    p2_div.rem_x = '0;
    p2_div.rem_y = '0;
    p2_div.nq_x  = p2_mag_x[NumW-1:0];
    p2_div.nq_y  = p2_mag_y[NumW-1:0];
    p2_div.z     = p2_star_q.z;
    // Saturate to zero at or beyond full depth
    if (32'(p2_star_q.z) >= FULL_DEPTH) begin
      p2_div.dot = '0;
    end else begin
      p2_div.dot = DotW'((32'(p2_dd) * 4) / FULL_DEPTH);
    end
  end

  // Divider pipeline: one quotient bit per stage for x and y
  logic dv_vld_q [0:NumW];
  div_t dv_q     [0:NumW];
  div_t dv_d     [1:NumW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= p2_div;
    end
  end

  for (genvar g = 0; g < NumW; g++) begin : g_div
    logic [DepthW:0] tx;
    logic [DepthW:0] ty;
    logic            ge_x;
    logic            ge_y;

    // Shift in the next numerator bit, subtract the depth where it fits
    always_comb begin
      tx   = {dv_q[g].rem_x, dv_q[g].nq_x[NumW-1]};
      ty   = {dv_q[g].rem_y, dv_q[g].nq_y[NumW-1]};
      ge_x = (tx >= {1'b0, dv_q[g].z});
      ge_y = (ty >= {1'b0, dv_q[g].z});
      dv_d[g+1]       = dv_q[g];
      dv_d[g+1].rem_x = ge_x ? DepthW'(tx - {1'b0, dv_q[g].z}) : tx[DepthW-1:0];
      dv_d[g+1].rem_y = ge_y ? DepthW'(ty - {1'b0, dv_q[g].z}) : ty[DepthW-1:0];
      dv_d[g+1].nq_x  = {dv_q[g].nq_x[NumW-2:0], ge_x};
      dv_d[g+1].nq_y  = {dv_q[g].nq_y[NumW-2:0], ge_y};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[g+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[g+1] <= dv_vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[g+1] <= dv_d[g+1];
      end
    end
  end

  // Bounds check and result forming
  div_t fin;
  logic fin_vld;
  logic fin_x_ok;
  logic fin_y_ok;
  res_t fin_res;

  always_comb begin
    fin      = dv_q[NumW];
    fin_vld  = dv_vld_q[NumW];
    // A negative quotient is on screen only when it truncates to zero
    fin_x_ok = fin.neg_x ? (fin.nq_x == '0) : (32'(fin.nq_x) < SCREEN_W);
    fin_y_ok = fin.neg_y ? (fin.nq_y == '0) : (32'(fin.nq_y) < SCREEN_H);
    fin_res.vis = fin.proj && fin_x_ok && fin_y_ok;
    fin_res.px  = fin_res.vis ? fin.nq_x[PxW-1:0] : '0;
    fin_res.py  = fin_res.vis ? fin.nq_y[PyW-1:0] : '0;
    fin_res.dot = fin_res.vis ? fin.dot : '0;
  end

  // Output register and skid register
  logic out_vld_q;
  res_t out_q;
  res_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (fin_vld) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (fin_vld) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_q <= fin_res;
      end else begin
        out_q <= fin_res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - PxW - PyW - DotW){1'b0}}, out_q.dot, out_q.py, out_q.px};
  assign m_axis_tuser  = out_q.vis;

endmodule

FILE: design/sfps_checker.sv
// Port-level checker for the starfield perspective step, bound to the top level.
module sfps_checker
  import sfps_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // Track requests accepted but not yet answered
  logic [7:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Every result answers an earlier request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 8'd0)
    else $error("result without pending request");

  // An off-screen result carries no pixel or dot
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("hidden result carries data");

  // Take no request when reset is released, while the store is being cleared
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("request taken during store clear");

endmodule

bind starfield_perspective_step sfps_checker u_sfps_checker (.*);
